### design/pfde_pkg.sv
`timescale 1ns / 1ps
package pfde_pkg;

  localparam int SCREEN_WIDTH = 128;
  localparam int SCREEN_PAGES = 8;
  localparam int MAX_SCALE    = 8;
  localparam int COL_W        = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W       = $clog2(SCREEN_PAGES);
  localparam int ADDR_W       = COL_W + PAGE_W;
  localparam int STORE_BYTES  = SCREEN_WIDTH * SCREEN_PAGES;
  localparam int SCREEN_ROWS  = SCREEN_PAGES * 8;
  localparam int CRD_W        = 11;

  localparam logic [2:0] MODE_PIXEL   = 3'd0;
  localparam logic [2:0] MODE_FILL    = 3'd1;
  localparam logic [2:0] MODE_OUTLINE = 3'd2;
  localparam logic [2:0] MODE_CHAR    = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;
  localparam logic [2:0] MODE_READ    = 3'd5;

  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd127;
  localparam logic [7:0] CHAR_QMARK = 8'd63;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       box_setup;
    logic [5:0] box_idx;
    logic       box_wr;
    logic       clr_start;
    logic       clr_wr;
    logic       out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic box_empty;
    logic box_last;
    logic clr_last;
  } dp_sts_t;

  localparam logic [7:0] FONT [480] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
    8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
    8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
    8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
    8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
    8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
    8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
    8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h03,8'h01,8'h71,8'h09,8'h07,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
    8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
    8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06,
    8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
    8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
    8'h7F,8'h09,8'h09,8'h01,8'h01, 8'h3E,8'h41,8'h41,8'h51,8'h32,
    8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
    8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h04,8'h02,8'h7F,
    8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
    8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
    8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F,
    8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03,
    8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h41,8'h41,8'h7F,8'h00,8'h00,
    8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20,
    8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18,
    8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h54,8'h54,8'h54,8'h3C,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00,
    8'h20,8'h40,8'h44,8'h3D,8'h00, 8'h00,8'h7F,8'h10,8'h28,8'h44,
    8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
    8'h7C,8'h14,8'h14,8'h14,8'h08, 8'h08,8'h14,8'h14,8'h18,8'h7C,
    8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C,
    8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h40,8'h30,8'h40,8'h3C,
    8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00,
    8'h00,8'h00,8'h7F,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,
    8'h08,8'h04,8'h08,8'h10,8'h08, 8'h00,8'h00,8'h00,8'h00,8'h00
  };

  // one font column; unknown codes map to question mark
  function automatic logic [7:0] font_col(input logic [7:0] code, input logic [2:0] col);
    logic [7:0] c;
    logic [8:0] idx;
    c = (code < CHAR_FIRST || code > CHAR_LAST) ? CHAR_QMARK : code;
    idx = 9'(c - CHAR_FIRST) * 9'd5 + 9'(col);
    return FONT[idx];
  endfunction

endpackage

### design/page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// read byte: a frame-store read, then the result; other draws: per box a setup and an
// empty check, then one read-modify-write in the frame store per store byte touched
// outline is 4 boxes, a character 40 boxes; clear zeroes every store byte
// one command at a time; a new command is taken once the result is queued
// reset: synchronous active low, then a clearing pass over the store with in_stall high
module page_framebuffer_draw_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_mode,
  input  logic signed [8:0] in_pos_x,
  input  logic signed [8:0] in_pos_y,
  input  logic [7:0]       in_rect_width,
  input  logic [7:0]       in_rect_height,
  input  logic             in_pixel_on,
  input  logic [7:0]       in_char_code,
  input  logic [3:0]       in_glyph_scale,
  input  logic [2:0]       in_read_page,
  input  logic [6:0]       in_read_column,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_read_data
);
  import pfde_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  pfde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // store and box walker
  pfde_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_pixel_on    (in_pixel_on),
    .in_char_code   (in_char_code),
    .in_glyph_scale (in_glyph_scale),
    .in_read_page   (in_read_page),
    .in_read_column (in_read_column),
    .out_read_data  (out_read_data),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

### design/pfde_ctrl.sv
`timescale 1ns / 1ps
module pfde_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_mode,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output pfde_pkg::dp_cmd_t cmd,
  input  pfde_pkg::dp_sts_t sts
);
  import pfde_pkg::*;

  typedef enum logic [8:0] {
    S_RCLR  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SETUP = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_RD    = 9'b000010000,
    S_WR    = 9'b000100000,
    S_CLR   = 9'b001000000,
    S_RDB   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] box_idx_r, box_idx_nxt;
  logic [5:0] last_idx_r, last_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, box_done, out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign box_done = (state_r == S_CHECK && sts.box_empty) ||
                    (state_r == S_WR && sts.box_last);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    box_idx_nxt   = box_idx_r;
    last_idx_nxt  = last_idx_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.box_idx   = box_idx_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_RCLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load    = 1'b1;
          box_idx_nxt = '0;
          case (in_mode)
            MODE_PIXEL, MODE_FILL: begin
              last_idx_nxt = 6'd0;
              state_nxt    = S_SETUP;
            end
            MODE_OUTLINE: begin
              last_idx_nxt = 6'd3;
              state_nxt    = S_SETUP;
            end
            MODE_CHAR: begin
              last_idx_nxt = 6'd39;
              state_nxt    = S_SETUP;
            end
            MODE_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLR;
            end
            MODE_READ: state_nxt = S_RDB;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SETUP: begin
        cmd.box_setup = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.box_empty) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_WR;
      S_WR: begin
        cmd.box_wr = 1'b1;
        if (!sts.box_last) state_nxt = S_RD;
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_RDB: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // step to the next box of the command
    if (box_done) begin
      if (box_idx_r == last_idx_r) begin
        state_nxt = S_DONE;
      end else begin
        box_idx_nxt = box_idx_r + 6'd1;
        state_nxt   = S_SETUP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RCLR;
      box_idx_r   <= '0;
      last_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      box_idx_r   <= box_idx_nxt;
      last_idx_r  <= last_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/pfde_dpath.sv
`timescale 1ns / 1ps
module pfde_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [2:0]       in_mode,
  input  logic signed [8:0] in_pos_x,
  input  logic signed [8:0] in_pos_y,
  input  logic [7:0]       in_rect_width,
  input  logic [7:0]       in_rect_height,
  input  logic             in_pixel_on,
  input  logic [7:0]       in_char_code,
  input  logic [3:0]       in_glyph_scale,
  input  logic [2:0]       in_read_page,
  input  logic [6:0]       in_read_column,
  output logic [7:0]       out_read_data,
  input  pfde_pkg::dp_cmd_t cmd,
  output pfde_pkg::dp_sts_t sts
);
  import pfde_pkg::*;

  // latched command
  logic [2:0]              mode_r;
  logic signed [CRD_W-1:0] x_r, y_r;
  logic [7:0]              w_r, h_r;
  logic                    on_r;
  logic [7:0]              code_r;
  logic [3:0]              scale_r;

  // box walker
  logic signed [CRD_W-1:0] x0_r, x1_r, y0_r, y1_r;
  logic                    bon_r;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [PAGE_W-1:0]       page_r, page_nxt;
  logic [7:0]              rdata_r, out_read_data_r;
  logic [7:0]              mem [STORE_BYTES];

  logic signed [CRD_W-1:0] bx, by, bw, bh, ex, ey;
  logic signed [CRD_W-1:0] cx0, cx1, cy0, cy1;
  logic                    bon;
  logic [3:0]              s;
  logic [2:0]              gcol, grow;
  logic [7:0]              gbits, mask, wdata;
  logic [ADDR_W-1:0]       addr;
  logic                    we, last_col, last_page;

  assign s    = (scale_r > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : scale_r;
  assign gcol = cmd.box_idx[5:3];
  assign grow = cmd.box_idx[2:0];
  assign gbits = font_col(code_r, gcol);

  // geometry of the current box
  always_comb begin
    bx  = x_r;
    by  = y_r;
    bw  = CRD_W'(w_r);
    bh  = CRD_W'(h_r);
    bon = on_r;
    case (mode_r)
      MODE_PIXEL: begin
        bw = CRD_W'(1);
        bh = CRD_W'(1);
      end
      MODE_OUTLINE: begin
        if (w_r == 8'd0 || h_r == 8'd0) begin
          bw = '0;
        end else begin
          case (cmd.box_idx[1:0])
            2'd0: bh = CRD_W'(1);
            2'd1: begin
              by = y_r + CRD_W'(h_r) - CRD_W'(1);
              bh = CRD_W'(1);
            end
            2'd2: bw = CRD_W'(1);
            default: begin
              bx = x_r + CRD_W'(w_r) - CRD_W'(1);
              bw = CRD_W'(1);
            end
          endcase
        end
      end
      MODE_CHAR: begin
        bx  = x_r + CRD_W'(gcol) * CRD_W'(s);
        by  = y_r + CRD_W'(grow) * CRD_W'(s);
        bw  = CRD_W'(s);
        bh  = CRD_W'(s);
        bon = gbits[grow];
      end
      default: ;
    endcase
    ex  = bx + bw;
    ey  = by + bh;
    cx0 = (bx < 0) ? '0 : bx;
    cy0 = (by < 0) ? '0 : by;
    cx1 = (ex > CRD_W'(SCREEN_WIDTH)) ? CRD_W'(SCREEN_WIDTH) : ex;
    cy1 = (ey > CRD_W'(SCREEN_ROWS)) ? CRD_W'(SCREEN_ROWS) : ey;
  end

  // rows of the current page inside the box
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = (CRD_W'({page_r, 3'(b)}) >= y0_r) && (CRD_W'({page_r, 3'(b)}) < y1_r);
    end
  end

  assign last_col  = (CRD_W'(col_r) == x1_r - CRD_W'(1));
  assign last_page = (CRD_W'(page_r) == ((y1_r - CRD_W'(1)) >>> 3));
  assign sts.box_empty = (x0_r >= x1_r) || (y0_r >= y1_r);
  assign sts.box_last  = last_col && last_page;
  assign sts.clr_last  = (&col_r) && (&page_r);

  assign wdata = cmd.clr_wr ? 8'h00 : (bon_r ? (rdata_r | mask) : (rdata_r & ~mask));
  assign we    = cmd.clr_wr || cmd.box_wr;
  assign addr  = {page_r, col_r};

  // byte walk and sweep counters
  always_comb begin
    col_nxt  = col_r;
    page_nxt = page_r;
    if (cmd.load) begin
      col_nxt  = in_read_column;
      page_nxt = in_read_page;
    end
    if (cmd.clr_start) begin
      col_nxt  = '0;
      page_nxt = '0;
    end else if (cmd.box_setup) begin
      col_nxt  = cx0[COL_W-1:0];
      page_nxt = cy0[PAGE_W+2:3];
    end else if (cmd.clr_wr) begin
      {page_nxt, col_nxt} = addr + ADDR_W'(1);
    end else if (cmd.box_wr) begin
      if (last_col) begin
        col_nxt  = x0_r[COL_W-1:0];
        page_nxt = page_r + PAGE_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      page_r <= '0;
    end else begin
      col_r  <= col_nxt;
      page_r <= page_nxt;
    end
  end

  // command and box registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      x_r     <= CRD_W'(in_pos_x);
      y_r     <= CRD_W'(in_pos_y);
      w_r     <= in_rect_width;
      h_r     <= in_rect_height;
      on_r    <= in_pixel_on;
      code_r  <= in_char_code;
      scale_r <= in_glyph_scale;
    end
    if (cmd.box_setup) begin
      x0_r  <= cx0;
      x1_r  <= cx1;
      y0_r  <= cy0;
      y1_r  <= cy1;
      bon_r <= bon;
    end
    if (cmd.out_load) begin
      out_read_data_r <= (mode_r == MODE_READ) ? rdata_r : 8'h00;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  assign out_read_data = out_read_data_r;

endmodule

### design/pfde_checker.sv
`timescale 1ns / 1ps
module pfde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

  // reset starts the clearing pass, no word taken
  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  // no result from a block that was idle and empty
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !out_valid |=> !out_valid)
    else $error("result without command");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data)
);
